FILE: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define AST_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// same-cycle implication
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Types and constants of the footswitch gesture detector.
// ----------------------------------------------------------------------------
package fsg_pkg;

    typedef logic [31:0] t_ms;
    typedef logic [15:0] t_ms16;
    typedef logic [2:0]  t_mode;
    typedef logic [1:0]  t_edge;
    typedef logic [5:0]  t_trig;
    typedef logic [2:0]  t_cfg_idx;

    localparam t_ms DEBOUNCE_MS = 32'd5;

    localparam t_mode MODE_TAP       = 3'd0;
    localparam t_mode MODE_MOMENTARY = 3'd1;
    localparam t_mode MODE_LATCHED   = 3'd2;
    localparam t_mode MODE_LONG_ALT  = 3'd3;
    localparam t_mode MODE_DOUBLE    = 3'd4;

    localparam t_trig TRG_PRESS   = 6'h01;
    localparam t_trig TRG_RELEASE = 6'h02;
    localparam t_trig TRG_TOG_ON  = 6'h04;
    localparam t_trig TRG_TOG_OFF = 6'h08;
    localparam t_trig TRG_LONG    = 6'h10;
    localparam t_trig TRG_DOUBLE  = 6'h20;

    localparam t_edge EDGE_NONE    = 2'd0;
    localparam t_edge EDGE_PRESS   = 2'd1;
    localparam t_edge EDGE_RELEASE = 2'd2;

    localparam t_cfg_idx CFG_SWITCH_MODE   = 3'd0;
    localparam t_cfg_idx CFG_LONG_PRESS    = 3'd1;
    localparam t_cfg_idx CFG_DOUBLE_WINDOW = 3'd2;
    localparam t_cfg_idx CFG_AUTO_MOM_MS   = 3'd3;
    localparam t_cfg_idx CFG_AUTO_MOM_EN   = 3'd4;

    localparam t_ms16 RST_LONG_PRESS    = 16'd600;
    localparam t_ms16 RST_DOUBLE_WINDOW = 16'd250;
    localparam t_ms16 RST_AUTO_MOM_MS   = 16'd500;

endpackage

FILE: rtl/footswitch_gesture_fsm_core.sv
// ----------------------------------------------------------------------------
// footswitch_gesture_fsm_core
// Debounces a footswitch sample stream and raises gesture triggers per mode.
//
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_stall    i_cmd, i_now_ms, i_raw_level
// out       source     o_out_valid / i_out_stall  o_edge_res, o_triggers,
//                                                 o_momentary_active
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while the output does not stall; an
// accepted input is held in the input register and its result then in the
// result register
// gesture state updates as an item moves from input to result register
// o_in_stall rises only while both registers are full and the output stalls
// synchronous active-low reset clears control and gesture state
// ----------------------------------------------------------------------------
module footswitch_gesture_fsm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  fsg_pkg::t_ms        i_now_ms,
    input  logic                i_raw_level,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fsg_pkg::t_edge      o_edge_res,
    output fsg_pkg::t_trig      o_triggers,
    output logic                o_momentary_active,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  fsg_pkg::t_cfg_idx   i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import fsg_pkg::*;

    // configuration
    t_mode r_mode;
    t_ms16 r_long_ms;
    t_ms16 r_window_ms;
    t_ms16 r_auto_ms;
    logic  r_auto_en;

    // input register
    logic  r_in_valid;
    logic  r_in_cmd;
    t_ms   r_in_now;
    logic  r_in_raw;

    // result register
    logic  r_out_valid;
    t_edge r_out_edge;
    t_trig r_out_trig;
    logic  r_out_mom;

    // gesture state
    logic  r_prev_raw, n_prev_raw;
    logic  r_stable, n_stable;
    t_ms   r_raw_change, n_raw_change;
    t_ms   r_press_start, n_press_start;
    logic  r_long_fired, n_long_fired;
    logic  r_latched, n_latched;
    logic  r_latched_before, n_latched_before;
    logic  r_tap_waiting, n_tap_waiting;
    t_ms   r_tap_deadline, n_tap_deadline;

    logic  advance;
    t_edge n_edge;
    t_trig n_trig;
    logic  n_mom;

    t_ms   db_age;
    t_ms   held;
    t_ms   dl_diff;
    t_ms   mom_held;
    logic  fire;
    logic  press_ev;
    logic  release_ev;
    logic  dl_not_after;
    logic  dbl_hit;
    logic  held_lt_long;
    logic  held_ge_auto;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;

    always_comb begin
        n_prev_raw       = r_prev_raw;
        n_stable         = r_stable;
        n_raw_change     = r_raw_change;
        n_press_start    = r_press_start;
        n_long_fired     = r_long_fired;
        n_latched        = r_latched;
        n_latched_before = r_latched_before;
        n_tap_waiting    = r_tap_waiting;
        n_tap_deadline   = r_tap_deadline;
        n_edge           = EDGE_NONE;
        n_trig           = '0;
        n_mom            = 1'b0;

        db_age       = (r_in_raw != r_prev_raw) ? '0 : (r_in_now - r_raw_change);
        fire         = (r_in_raw != r_stable) && (db_age >= DEBOUNCE_MS);
        press_ev     = fire && !r_in_raw;
        release_ev   = fire && r_in_raw;
        held         = r_in_now - r_press_start;
        dl_diff      = r_in_now - r_tap_deadline;
        dl_not_after = (dl_diff == '0) || dl_diff[31];
        dbl_hit      = r_tap_waiting && dl_not_after;
        held_lt_long = held < {16'd0, r_long_ms};
        held_ge_auto = held >= {16'd0, r_auto_ms};
        mom_held     = held;

        if (r_in_cmd) begin
            n_press_start    = '0;
            n_long_fired     = !r_stable;
            n_latched        = 1'b0;
            n_latched_before = 1'b0;
            n_tap_waiting    = 1'b0;
            n_tap_deadline   = '0;
            mom_held         = r_in_now;
        end else begin
            if (r_in_raw != r_prev_raw) begin
                n_prev_raw   = r_in_raw;
                n_raw_change = r_in_now;
            end
            if (fire) begin
                n_stable = r_in_raw;
            end
            if (press_ev) begin
                n_edge = EDGE_PRESS;
                unique case (r_mode)
                    MODE_TAP, MODE_MOMENTARY: begin
                        n_trig = TRG_PRESS;
                    end
                    MODE_LATCHED: begin
                        n_latched_before = r_latched;
                        n_press_start    = r_in_now;
                        n_latched        = !r_latched;
                        n_trig           = r_latched ? TRG_TOG_OFF : TRG_TOG_ON;
                        mom_held         = '0;
                    end
                    MODE_LONG_ALT: begin
                        n_press_start = r_in_now;
                        n_long_fired  = 1'b0;
                        mom_held      = '0;
                    end
                    MODE_DOUBLE: begin
                        if (dbl_hit) begin
                            n_tap_waiting = 1'b0;
                            n_trig        = TRG_DOUBLE;
                        end else begin
                            n_tap_waiting  = 1'b1;
                            n_tap_deadline = r_in_now + {16'd0, r_window_ms};
                        end
                    end
                    default: begin
                        n_trig = '0;
                    end
                endcase
            end else if (release_ev) begin
                n_edge = EDGE_RELEASE;
                priority if (r_mode == MODE_MOMENTARY) begin
                    n_trig = TRG_RELEASE;
                end else if (r_mode == MODE_LONG_ALT && !r_long_fired && held_lt_long) begin
                    n_trig = TRG_PRESS;
                end else if (r_mode == MODE_LATCHED && r_auto_en && held_ge_auto &&
                             (r_latched != r_latched_before)) begin
                    n_latched = r_latched_before;
                    n_trig    = r_latched_before ? TRG_TOG_ON : TRG_TOG_OFF;
                end else begin
                    n_trig = '0;
                end
            end
            // mom_held doubles as the post-press hold time for long press
            if (r_mode == MODE_LONG_ALT && !n_stable && !n_long_fired &&
                mom_held >= {16'd0, r_long_ms}) begin
                n_long_fired = 1'b1;
                n_trig       = n_trig | TRG_LONG;
            end
            // an expired double-mode window raises TRG_PRESS unless a press restarts it
            if (r_mode == MODE_DOUBLE && !press_ev && r_tap_waiting && !dl_not_after) begin
                n_tap_waiting = 1'b0;
                n_trig        = n_trig | TRG_PRESS;
            end
        end

        n_mom = (r_mode == MODE_LATCHED) && r_auto_en && !n_stable &&
                (mom_held >= {16'd0, r_auto_ms});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TAP;
            r_long_ms   <= RST_LONG_PRESS;
            r_window_ms <= RST_DOUBLE_WINDOW;
            r_auto_ms   <= RST_AUTO_MOM_MS;
            r_auto_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SWITCH_MODE:   r_mode      <= i_cfg_data[2:0];
                CFG_LONG_PRESS:    r_long_ms   <= i_cfg_data;
                CFG_DOUBLE_WINDOW: r_window_ms <= i_cfg_data;
                CFG_AUTO_MOM_MS:   r_auto_ms   <= i_cfg_data;
                CFG_AUTO_MOM_EN:   r_auto_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd <= i_cmd;
            r_in_now <= i_now_ms;
            r_in_raw <= i_raw_level;
        end
        if (advance) begin
            r_out_edge <= n_edge;
            r_out_trig <= n_trig;
            r_out_mom  <= n_mom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw       <= 1'b1;
            r_stable         <= 1'b1;
            r_raw_change     <= '0;
            r_press_start    <= '0;
            r_long_fired     <= 1'b0;
            r_latched        <= 1'b0;
            r_latched_before <= 1'b0;
            r_tap_waiting    <= 1'b0;
            r_tap_deadline   <= '0;
        end else if (advance) begin
            r_prev_raw       <= n_prev_raw;
            r_stable         <= n_stable;
            r_raw_change     <= n_raw_change;
            r_press_start    <= n_press_start;
            r_long_fired     <= n_long_fired;
            r_latched        <= n_latched;
            r_latched_before <= n_latched_before;
            r_tap_waiting    <= n_tap_waiting;
            r_tap_deadline   <= n_tap_deadline;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_edge_res         = r_out_edge;
    assign o_triggers         = r_out_trig;
    assign o_momentary_active = r_out_mom;

endmodule

FILE: rtl/fsg_checker.sv
// ----------------------------------------------------------------------------
// fsg_checker
// Port-level checks on the footswitch gesture detector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fsg_pkg::t_edge      o_edge_res,
    input fsg_pkg::t_trig      o_triggers,
    input logic                o_cfg_ready
);
    import fsg_pkg::*;

    localparam t_trig EDGE_ONLY_TRIG = TRG_RELEASE | TRG_TOG_ON | TRG_TOG_OFF | TRG_DOUBLE;

    logic edge_known;
    logic out_no_edge;
    logic edge_trig_seen;
    logic out_held;

    assign edge_known     = (o_edge_res == EDGE_NONE) || (o_edge_res == EDGE_PRESS) ||
                            (o_edge_res == EDGE_RELEASE);
    assign out_no_edge    = o_out_valid && (o_edge_res == EDGE_NONE);
    assign edge_trig_seen = |(o_triggers & EDGE_ONLY_TRIG);
    assign out_held       = o_out_valid && i_out_stall;

    `AST_IMPLY(a_edge_code, i_clk, i_rst_n, o_out_valid, edge_known, "bad edge code")
    `AST_IMPLY(a_no_edge_trig, i_clk, i_rst_n, out_no_edge, !edge_trig_seen, "trigger without edge")
    `AST_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, out_held, "stall without output stall")
    `AST_ALWAYS(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready, "config port not ready")
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid, "stalled result dropped")

endmodule

bind footswitch_gesture_fsm_core fsg_checker u_fsg_checker (.*);
